// ===== sv/deq_pkg.sv =====
// Shared types, sizes and ring-index helpers for the double-ended queue.
// No dependencies; deq_ctrl and double_ended_queue_unit import this package.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_WIDE = (ADDR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    // Memory access request for one command, plus write-to-read forward hits
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_front_addr;
        logic [ADDR_W-1:0] rd_back_addr;
        logic              fwd_front;
        logic              fwd_back;
    } t_deq_op;

    // Registered status of the last transfer
    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic             empty;
        logic             full;
        logic             rejected;
    } t_deq_stat;

    function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? LAST_SLOT : a - 1'b1;
    endfunction

    // Sum of two slot positions, wrapped once into the ring
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_WIDE) begin
            sum = sum - DEPTH_WIDE;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== sv/deq_ram.sv =====
// Generic simple-dual-read RAM: one write port, two registered read ports.
// No dependencies.
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]                       o_rd_data_a,
    output logic [WIDTH-1:0]                       o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

// ===== sv/deq_ctrl.sv =====
// Pointer and count control: decodes commands, updates the front index and count.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_command,
    output deq_pkg::t_deq_op   o_op,
    output deq_pkg::t_deq_stat o_stat
);
    import deq_pkg::*;

    logic [ADDR_W-1:0] r_front;
    logic [CNT_W-1:0]  r_count;
    logic              r_rejected;
    logic [ADDR_W-1:0] n_front;
    logic [CNT_W-1:0]  n_count;
    logic              n_rejected;
    logic [CNT_W-1:0]  back_offset;
    logic              is_full;
    logic              is_empty;

    assign is_full  = (r_count == FULL_COUNT);
    assign is_empty = (r_count == '0);

    // Decode the command into new pointers and a slot write
    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        n_rejected    = 1'b0;
        o_op.wr_en    = 1'b0;
        o_op.wr_addr  = slot_dec(r_front);
        case (t_cmd'(i_command))
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_rejected = 1'b1;
                end else begin
                    n_front      = slot_dec(r_front);
                    n_count      = r_count + 1'b1;
                    o_op.wr_en   = 1'b1;
                    o_op.wr_addr = slot_dec(r_front);
                end
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_rejected = 1'b1;
                end else begin
                    n_count      = r_count + 1'b1;
                    o_op.wr_en   = 1'b1;
                    o_op.wr_addr = slot_add(r_front, r_count[ADDR_W-1:0]);
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    n_rejected = 1'b1;
                end else begin
                    n_front = slot_inc(r_front);
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    n_rejected = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                n_front = r_front;
            end
        endcase

        // Read both ends after the update; flag reads that hit the slot being written
        back_offset        = n_count - 1'b1;
        o_op.rd_front_addr = n_front;
        o_op.rd_back_addr  = slot_add(n_front, back_offset[ADDR_W-1:0]);
        o_op.fwd_front     = o_op.wr_en && (o_op.wr_addr == o_op.rd_front_addr);
        o_op.fwd_back      = o_op.wr_en && (o_op.wr_addr == o_op.rd_back_addr);
    end

    // Advance state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_rejected <= 1'b0;
        end else if (i_accept) begin
            r_front    <= n_front;
            r_count    <= n_count;
            r_rejected <= n_rejected;
        end
    end

    assign o_stat.total    = r_count;
    assign o_stat.empty    = is_empty;
    assign o_stat.full     = is_full;
    assign o_stat.rejected = r_rejected;

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// Bounded double-ended queue of 16 signed 32-bit words held in a ring RAM. At
// each command's input transfer the front index and count are updated, a push
// writes its slot, and both end slots are read in the same cycle, with the
// pushed word forwarded when it lands on an end. The result sits in an output
// register the next cycle; a new command is taken whenever that register is
// empty or is being drained, so throughput is one command per cycle when
// results are taken at once. Pops on empty and pushes on full are flagged as
// rejected and leave the queue unchanged. Slots need no clearing after reset.
// Depends on deq_pkg, deq_ctrl and deq_ram.
module double_ended_queue_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [2:0]                           i_command,
    input  logic signed [deq_pkg::DATA_WIDTH-1:0] i_data_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [deq_pkg::DATA_WIDTH-1:0] o_front_value,
    output logic signed [deq_pkg::DATA_WIDTH-1:0] o_back_value,
    output logic [deq_pkg::CNT_W-1:0]            o_entry_total,
    output logic                                 o_is_empty,
    output logic                                 o_is_full,
    output logic                                 o_rejected
);
    import deq_pkg::*;

    t_deq_op               op;
    t_deq_stat             stat;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  r_out_valid;
    logic                  r_fwd_front;
    logic                  r_fwd_back;
    logic [DATA_WIDTH-1:0] r_fwd_data;
    logic [DATA_WIDTH-1:0] rd_front;
    logic [DATA_WIDTH-1:0] rd_back;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign o_stall  = r_out_valid && i_stall;

    deq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_xfer),
        .i_command (i_command),
        .o_op      (op),
        .o_stat    (stat)
    );

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (in_xfer && op.wr_en),
        .i_wr_addr   (op.wr_addr),
        .i_wr_data   (i_data_value),
        .i_rd_en     (in_xfer),
        .i_rd_addr_a (op.rd_front_addr),
        .i_rd_addr_b (op.rd_back_addr),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_back)
    );

    // Capture forward hits alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fwd_front <= op.fwd_front;
            r_fwd_back  <= op.fwd_back;
            r_fwd_data  <= i_data_value;
        end
    end

    // Hold the result until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Select ends; an empty queue reports zero words
    assign o_valid       = r_out_valid;
    assign o_front_value = stat.empty ? '0 : (r_fwd_front ? r_fwd_data : rd_front);
    assign o_back_value  = stat.empty ? '0 : (r_fwd_back ? r_fwd_data : rd_back);
    assign o_entry_total = stat.total;
    assign o_is_empty    = stat.empty;
    assign o_is_full     = stat.full;
    assign o_rejected    = stat.rejected;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_valid)
        else $error("no result after input transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_total <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_total == CNT_W'(1)) |-> (o_front_value == o_back_value))
        else $error("front and back differ with one entry");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (!o_rejected || o_entry_total == $past(o_entry_total)))
        else $error("rejected command changed the count");

endmodule
